// File: hdl/sbmq_pkg.sv
// sbmq_pkg: sizes, codes and shared types of the shared-buffer multi-queue block
// used by every module under hdl but sbmq_ram; depends on nothing
`timescale 1ns / 1ps

package sbmq_pkg;

    localparam int SLOTS      = 128;
    localparam int QUEUES     = 16;
    localparam int DATA_WIDTH = 32;

    // field and register widths fixed by the interface
    localparam int QF_W  = 4;
    localparam int AQ_W  = 5;
    localparam int CAP_W = 8;
    localparam int CFG_W = 8;

    // slot pointer holds 0..SLOTS, SLOTS being the null link
    localparam int PTR_W = $clog2(SLOTS + 1);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int QID_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int CNT_W = ((PTR_W > CAP_W) ? PTR_W : CAP_W) + 1;

    localparam int IN_DATA_W  = ((QF_W + DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DATA_WIDTH + 1 + 7) / 8) * 8;

    typedef logic [PTR_W-1:0] ptr_t;

    localparam ptr_t NIL_PTR = PTR_W'(SLOTS);

    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_DEQUEUE = 1'b1;

    localparam logic REG_ACTIVE_QUEUES = 1'b0;
    localparam logic REG_CAPACITY      = 1'b1;

    localparam logic [AQ_W-1:0] ACTIVE_RESET = AQ_W'(16);

    typedef enum logic [1:0]
    {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    // controller to datapath
    typedef struct packed
    {
        logic accept;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic out_free;
    } dp_stat_t;

endpackage

// File: hdl/sbmq_ram.sv
// sbmq_ram: generic single-write, single-read RAM with registered read data
// depends on nothing
`timescale 1ns / 1ps

module sbmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sbmq_ctrl.sv
// sbmq_ctrl: two-state controller, accept then execute
// depends on sbmq_pkg
`timescale 1ns / 1ps

module sbmq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sbmq_pkg::dp_stat_t stat,
    output sbmq_pkg::dp_cmd_t  cmd
);

    import sbmq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.accept = 1'b0;
        cmd.commit = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // hold until the result register can take the result
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/sbmq_datapath.sv
// sbmq_datapath: queue pointers, free list, slot RAMs and result register
// depends on sbmq_pkg and sbmq_ram
`timescale 1ns / 1ps

module sbmq_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sbmq_pkg::dp_cmd_t                cmd,
    output sbmq_pkg::dp_stat_t               stat,
    input  logic                             in_cmd,
    input  logic [sbmq_pkg::QF_W-1:0]        in_queue_id,
    input  logic [sbmq_pkg::DATA_WIDTH-1:0]  in_value,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [sbmq_pkg::CFG_W-1:0]       cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sbmq_pkg::DATA_WIDTH-1:0]  out_read_value,
    output sbmq_pkg::status_t                out_status,
    output logic                             out_queue_empty
);

    import sbmq_pkg::*;

    ptr_t head_reg [QUEUES];
    ptr_t tail_reg [QUEUES];
    ptr_t free_head_reg;
    ptr_t fresh_reg;
    ptr_t cnt_reg;
    logic [AQ_W-1:0] active_reg;

    logic                  cmd_reg;
    logic [QF_W-1:0]       qid_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    ptr_t                  head_sel_reg;
    ptr_t                  tail_sel_reg;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] out_value_reg;
    status_t               out_status_reg;
    logic                  out_empty_reg;

    logic [QID_W-1:0] in_qidx;
    logic [QID_W-1:0] qidx;
    ptr_t             in_head;
    ptr_t             in_tail;
    ptr_t             link_raddr;

    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    ptr_t                  link_wdata;
    ptr_t                  link_rdata;
    logic                  data_we;
    logic [DATA_WIDTH-1:0] data_rdata;

    logic                  invalid;
    logic                  head_we;
    ptr_t                  head_wdata;
    logic                  tail_we;
    ptr_t                  tail_wdata;
    logic                  free_we;
    ptr_t                  free_wdata;
    logic                  fresh_inc;
    ptr_t                  fresh_link;
    logic [DATA_WIDTH-1:0] res_value;
    status_t               res_status;
    logic                  res_empty;

    logic [CNT_W-1:0]      cap_ext;
    ptr_t                  cap_cnt;

    assign in_qidx    = QID_W'(in_queue_id);
    assign qidx       = QID_W'(qid_reg);
    assign in_head    = head_reg[in_qidx];
    assign in_tail    = tail_reg[in_qidx];
    assign link_raddr = (in_cmd == CMD_DEQUEUE) ? in_head : free_head_reg;

    assign stat.out_free = !out_valid_reg || out_ready;

    // capacity saturates at the slot count
    assign cap_ext = CNT_W'(cfg_data);
    assign cap_cnt = (cap_ext >= CNT_W'(SLOTS)) ? NIL_PTR : PTR_W'(cfg_data);

    // link of a never-used slot follows the initial chain
    assign fresh_link = ((CNT_W'(free_head_reg) + CNT_W'(1)) < CNT_W'(cnt_reg))
                        ? free_head_reg + PTR_W'(1) : NIL_PTR;

    sbmq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (cmd.accept),
        .raddr (IDX_W'(link_raddr)),
        .rdata (link_rdata)
    );

    sbmq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (IDX_W'(free_head_reg)),
        .wdata (value_reg),
        .re    (cmd.accept),
        .raddr (IDX_W'(in_head)),
        .rdata (data_rdata)
    );

    always_comb
    begin
        invalid    = (AQ_W'(qid_reg) >= active_reg) || (32'(qid_reg) >= 32'(QUEUES));
        link_we    = 1'b0;
        link_waddr = IDX_W'(free_head_reg);
        link_wdata = free_head_reg;
        data_we    = 1'b0;
        head_we    = 1'b0;
        head_wdata = head_sel_reg;
        tail_we    = 1'b0;
        tail_wdata = tail_sel_reg;
        free_we    = 1'b0;
        free_wdata = free_head_reg;
        fresh_inc  = 1'b0;
        res_value  = '0;
        res_status = ST_OK;
        res_empty  = 1'b0;
        if (invalid)
        begin
            res_status = ST_INVALID;
        end
        else if (cmd_reg == CMD_ENQUEUE)
        begin
            if (free_head_reg == NIL_PTR)
            begin
                res_status = ST_OVERFLOW;
                res_empty  = (head_sel_reg == NIL_PTR);
            end
            else
            begin
                data_we    = 1'b1;
                free_we    = 1'b1;
                tail_we    = 1'b1;
                tail_wdata = free_head_reg;
                if (free_head_reg >= fresh_reg)
                begin
                    fresh_inc  = 1'b1;
                    free_wdata = fresh_link;
                end
                else
                begin
                    free_wdata = link_rdata;
                end
                if (head_sel_reg == NIL_PTR)
                begin
                    head_we    = 1'b1;
                    head_wdata = free_head_reg;
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = IDX_W'(tail_sel_reg);
                    link_wdata = free_head_reg;
                end
            end
        end
        else
        begin
            if (head_sel_reg == NIL_PTR)
            begin
                res_status = ST_UNDERFLOW;
                res_value  = '1;
                res_empty  = 1'b1;
            end
            else
            begin
                res_value  = data_rdata;
                head_we    = 1'b1;
                link_we    = 1'b1;
                link_waddr = IDX_W'(head_sel_reg);
                link_wdata = free_head_reg;
                free_we    = 1'b1;
                free_wdata = head_sel_reg;
                if (head_sel_reg == tail_sel_reg)
                begin
                    head_wdata = NIL_PTR;
                    tail_we    = 1'b1;
                    tail_wdata = NIL_PTR;
                    res_empty  = 1'b1;
                end
                else
                begin
                    head_wdata = link_rdata;
                end
            end
        end
        if (!cmd.commit)
        begin
            link_we = 1'b0;
            data_we = 1'b0;
            head_we = 1'b0;
            tail_we = 1'b0;
            free_we = 1'b0;
            fresh_inc = 1'b0;
        end
    end

    // item latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg      <= in_cmd;
            qid_reg      <= in_queue_id;
            value_reg    <= in_value;
            head_sel_reg <= in_head;
            tail_sel_reg <= in_tail;
        end
    end

    // list pointers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < QUEUES; i++)
            begin
                head_reg[i] <= NIL_PTR;
                tail_reg[i] <= NIL_PTR;
            end
            free_head_reg <= '0;
            fresh_reg     <= '0;
            cnt_reg       <= NIL_PTR;
            active_reg    <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ACTIVE_QUEUES)
            begin
                active_reg <= AQ_W'(cfg_data);
            end
            else
            begin
                for (int i = 0; i < QUEUES; i++)
                begin
                    head_reg[i] <= NIL_PTR;
                    tail_reg[i] <= NIL_PTR;
                end
                cnt_reg       <= cap_cnt;
                fresh_reg     <= '0;
                free_head_reg <= (cap_cnt == '0) ? NIL_PTR : '0;
            end
        end
        else
        begin
            if (head_we)
            begin
                head_reg[qidx] <= head_wdata;
            end
            if (tail_we)
            begin
                tail_reg[qidx] <= tail_wdata;
            end
            if (free_we)
            begin
                free_head_reg <= free_wdata;
            end
            if (fresh_inc)
            begin
                fresh_reg <= fresh_reg + PTR_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_value_reg  <= res_value;
            out_status_reg <= res_status;
            out_empty_reg  <= res_empty;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_read_value  = out_value_reg;
    assign out_status      = out_status_reg;
    assign out_queue_empty = out_empty_reg;

endmodule

// File: hdl/shared_buffer_multi_queue.sv
// shared_buffer_multi_queue: top level, several FIFO queues in one shared slot store
// depends on sbmq_pkg, sbmq_ctrl, sbmq_datapath (and sbmq_ram below it)
//
//   channel   direction  handshake              payload
//   s_axis    in         tvalid / tready        tuser cmd, tdata queue_id, value
//   m_axis    out        tvalid / tready        tuser status, tdata read_value, queue_empty
//   cfg       in         cfg_we                 cfg_index, cfg_data
//
// each operation: accept and slot RAM read, then pointer update, before the next is accepted
// a stalled result is held in the output register; the next transfer is taken
// meanwhile, its update waits until the output register is free
// no clearing pass: reset and capacity writes set the queue and free list pointers directly
`timescale 1ns / 1ps

module shared_buffer_multi_queue (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [3:0] queue_id, [35:4] value, rest zero
    input  logic [sbmq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] cmd
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] read_value, [32] queue_empty, rest zero
    output logic [sbmq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [1:0] status
    output logic [1:0]                         m_axis_tuser,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [sbmq_pkg::CFG_W-1:0]         cfg_data
);

    import sbmq_pkg::*;

    dp_cmd_t               dp_cmd;
    dp_stat_t              dp_stat;
    logic [DATA_WIDTH-1:0] read_value;
    status_t               status;
    logic                  queue_empty;

    sbmq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    sbmq_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .stat            (dp_stat),
        .in_cmd          (s_axis_tuser),
        .in_queue_id     (s_axis_tdata[QF_W-1:0]),
        .in_value        (s_axis_tdata[QF_W+DATA_WIDTH-1:QF_W]),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_read_value  (read_value),
        .out_status      (status),
        .out_queue_empty (queue_empty)
    );

    assign m_axis_tdata = OUT_DATA_W'({queue_empty, read_value});
    assign m_axis_tuser = status;

endmodule

// File: bench/shared_buffer_multi_queue_test.sv
// shared_buffer_multi_queue_test: self-checking bench for the shared-buffer multi-queue block
// drives enqueue/dequeue transfers and register writes, predicts every result in place
// depends on sbmq_pkg and shared_buffer_multi_queue
`timescale 1ns / 1ps

module shared_buffer_multi_queue_test;

    import sbmq_pkg::*;

    typedef struct packed
    {
        logic [31:0] read_value;
        status_t     status;
        logic        queue_empty;
    } reply_t;

    typedef enum logic
    {
        ROW_OP  = 1'b0,
        ROW_REG = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t   kind;
        logic        cmd;
        logic [3:0]  qid;
        logic [31:0] word;
        logic        reg_idx;
        logic [7:0]  reg_data;
        logic        typed;
        reply_t      want;
    } step_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // predicted block state
    logic [31:0] slot_word [SLOTS];
    ptr_t        slot_next [SLOTS];
    ptr_t        q_head [QUEUES];
    ptr_t        q_tail [QUEUES];
    ptr_t        free_top;
    logic [4:0]  active_cnt;
    logic [7:0]  cap_cnt;

    reply_t reply_fifo [$];
    step_t  directed_rows [$];
    int     fail_count = 0;
    int     send_burst = 0;
    int     sink_mode = 0;
    int     sink_run = 0;

    shared_buffer_multi_queue u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    initial
    begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    function automatic void rebuild_free_list();
        int span;
        span = (cap_cnt > SLOTS) ? SLOTS : int'(cap_cnt);
        for (int i = 0; i < SLOTS; i++)
            slot_next[i] = (i + 1 < span) ? ptr_t'(i + 1) : NIL_PTR;
        for (int i = 0; i < QUEUES; i++)
        begin
            q_head[i] = NIL_PTR;
            q_tail[i] = NIL_PTR;
        end
        free_top = (span > 0) ? ptr_t'(0) : NIL_PTR;
    endfunction

    function automatic void apply_reg(input logic idx, input logic [7:0] data);
        if (idx == REG_ACTIVE_QUEUES)
            active_cnt = data[4:0];
        else
        begin
            cap_cnt = data;
            rebuild_free_list();
        end
    endfunction

    function automatic reply_t run_queue_op(input logic op, input logic [3:0] qid,
                                            input logic [31:0] word);
        reply_t r;
        ptr_t   slot;
        r.read_value  = '0;
        r.status      = ST_OK;
        r.queue_empty = 1'b0;
        if (qid >= active_cnt || qid >= QUEUES)
        begin
            r.status = ST_INVALID;
            return r;
        end
        if (op == CMD_ENQUEUE)
        begin
            slot = free_top;
            if (slot >= SLOTS)
                r.status = ST_OVERFLOW;
            else
            begin
                free_top = slot_next[slot];
                if (q_head[qid] >= SLOTS)
                    q_head[qid] = slot;
                else if (q_tail[qid] < SLOTS)
                    slot_next[q_tail[qid]] = slot;
                slot_next[slot] = NIL_PTR;
                q_tail[qid] = slot;
                slot_word[slot] = word;
            end
        end
        else
        begin
            slot = q_head[qid];
            if (slot >= SLOTS)
            begin
                r.status = ST_UNDERFLOW;
                r.read_value = '1;
            end
            else
            begin
                q_head[qid] = slot_next[slot];
                if (q_head[qid] >= SLOTS)
                begin
                    q_head[qid] = NIL_PTR;
                    q_tail[qid] = NIL_PTR;
                end
                slot_next[slot] = free_top;
                free_top = slot;
                r.read_value = slot_word[slot];
            end
        end
        r.queue_empty = (q_head[qid] >= SLOTS);
        return r;
    endfunction

    task automatic add_op(input logic op, input logic [3:0] qid, input logic [31:0] word);
        step_t row;
        row = '0;
        row.kind = ROW_OP;
        row.cmd = op;
        row.qid = qid;
        row.word = word;
        directed_rows.push_back(row);
    endtask

    task automatic add_chk(input logic op, input logic [3:0] qid, input logic [31:0] word,
                           input logic [31:0] rv, input status_t st, input logic empty);
        step_t row;
        row = '0;
        row.kind = ROW_OP;
        row.cmd = op;
        row.qid = qid;
        row.word = word;
        row.typed = 1'b1;
        row.want.read_value = rv;
        row.want.status = st;
        row.want.queue_empty = empty;
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(input logic idx, input logic [7:0] data);
        step_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_data = data;
        directed_rows.push_back(row);
    endtask

    task automatic push_op(input logic op, input logic [3:0] qid, input logic [31:0] word,
                           input logic typed, input reply_t want);
        reply_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {{(IN_DATA_W - 36){1'b0}}, word, qid};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = run_queue_op(op, qid, word);
        reply_fifo.push_back(typed ? want : predicted);
        if (send_burst > 0)
            send_burst--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            send_burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        s_axis_tvalid <= 1'b0;
        while (reply_fifo.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, data);
    endtask

    // receiver: runs of always ready, mostly ready, mostly stalled, or alternating
    always @(posedge clk)
    begin
        if (sink_run == 0)
        begin
            sink_mode <= $urandom_range(0, 3);
            sink_run <= $urandom_range(4, 40);
        end
        else
            sink_run <= sink_run - 1;
        case (sink_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ~m_axis_tready;
        endcase
    end

    always @(posedge clk)
    begin
        reply_t got;
        reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.read_value = m_axis_tdata[31:0];
            got.queue_empty = m_axis_tdata[32];
            got.status = status_t'(m_axis_tuser);
            if (reply_fifo.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected transfer: value %h status %0d empty %b",
                             got.read_value, got.status, got.queue_empty);
            end
            else
            begin
                want = reply_fifo.pop_front();
                if (got.read_value !== want.read_value || got.status !== want.status ||
                    got.queue_empty !== want.queue_empty)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: got value %h status %0d empty %b, want %h %0d %b",
                                 got.read_value, got.status, got.queue_empty,
                                 want.read_value, want.status, want.queue_empty);
                end
            end
        end
    end

    initial
    begin
        step_t       row;
        logic        op;
        logic [3:0]  qid;
        int          aq;
        int          cap;
        int          n_ops;
        int          top_q;
        bit          filling;

        // extremes and round trips with the reset setting
        add_chk(CMD_ENQUEUE, 4'd0, 32'h8000_0000, 32'h0, ST_OK, 1'b0);
        add_op(CMD_ENQUEUE, 4'd0, 32'h7FFF_FFFF);
        add_op(CMD_ENQUEUE, 4'd15, 32'hFFFF_FFFF);
        add_chk(CMD_DEQUEUE, 4'd0, 32'h0, 32'h8000_0000, ST_OK, 1'b0);
        add_chk(CMD_DEQUEUE, 4'd0, 32'h0, 32'h7FFF_FFFF, ST_OK, 1'b1);
        add_chk(CMD_DEQUEUE, 4'd0, 32'h0, 32'hFFFF_FFFF, ST_UNDERFLOW, 1'b1);
        add_chk(CMD_DEQUEUE, 4'd15, 32'hA5A5_A5A5, 32'hFFFF_FFFF, ST_OK, 1'b1);
        add_chk(CMD_DEQUEUE, 4'd15, 32'h0, 32'hFFFF_FFFF, ST_UNDERFLOW, 1'b1);
        // one queue, two slots: overflow and invalid queue numbers
        add_reg(REG_ACTIVE_QUEUES, 8'hE1);
        add_reg(REG_CAPACITY, 8'd2);
        add_op(CMD_ENQUEUE, 4'd0, 32'h0000_0000);
        add_op(CMD_ENQUEUE, 4'd0, 32'h1234_5678);
        add_chk(CMD_ENQUEUE, 4'd0, 32'h0000_0001, 32'h0, ST_OVERFLOW, 1'b0);
        add_chk(CMD_ENQUEUE, 4'd1, 32'h0000_0002, 32'h0, ST_INVALID, 1'b0);
        add_chk(CMD_DEQUEUE, 4'd15, 32'h0, 32'h0, ST_INVALID, 1'b0);
        // rewriting the same capacity empties every queue
        add_reg(REG_CAPACITY, 8'd2);
        add_chk(CMD_DEQUEUE, 4'd0, 32'h0, 32'hFFFF_FFFF, ST_UNDERFLOW, 1'b1);
        add_reg(REG_CAPACITY, 8'd0);
        add_chk(CMD_ENQUEUE, 4'd0, 32'hDEAD_BEEF, 32'h0, ST_OVERFLOW, 1'b1);
        add_reg(REG_ACTIVE_QUEUES, 8'd0);
        add_chk(CMD_ENQUEUE, 4'd0, 32'h0, 32'h0, ST_INVALID, 1'b0);
        // settings above the block's sizes saturate
        add_reg(REG_ACTIVE_QUEUES, 8'd31);
        add_reg(REG_CAPACITY, 8'd255);
        add_op(CMD_ENQUEUE, 4'd15, 32'h5555_AAAA);
        add_chk(CMD_DEQUEUE, 4'd15, 32'h0, 32'h5555_AAAA, ST_OK, 1'b1);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        active_cnt = ACTIVE_RESET;
        cap_cnt = 8'd128;
        for (int i = 0; i < SLOTS; i++)
            slot_word[i] = '0;
        rebuild_free_list();
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.reg_idx, row.reg_data);
            else
                push_op(row.cmd, row.qid, row.word, row.typed, row.want);
        end

        // random phases: fill towards overflow, then drain towards underflow
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:       begin aq = 16; cap = 128; n_ops = 300; end
                1:       begin aq = 4;  cap = 8;   n_ops = 80;  end
                2:       begin aq = 1;  cap = 1;   n_ops = 40;  end
                3:       begin aq = 16; cap = 24;  n_ops = 80;  end
                4:       begin aq = 31; cap = 200; n_ops = 60;  end
                5:       begin aq = 2;  cap = 0;   n_ops = 20;  end
                default: begin aq = 9;  cap = 5;   n_ops = 70;  end
            endcase
            write_reg(REG_ACTIVE_QUEUES, {3'($urandom), 5'(aq)});
            write_reg(REG_CAPACITY, 8'(cap));
            top_q = (aq > QUEUES) ? QUEUES - 1 : aq - 1;
            for (int k = 0; k < n_ops; k++)
            begin
                filling = (k < n_ops / 2);
                op = ($urandom_range(0, 99) < (filling ? 95 : 10)) ? CMD_ENQUEUE
                                                                    : CMD_DEQUEUE;
                if (top_q >= 0 && $urandom_range(0, 99) < 85)
                    qid = 4'($urandom_range(0, top_q));
                else
                    qid = 4'($urandom_range(0, 15));
                push_op(op, qid, $urandom, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (reply_fifo.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && reply_fifo.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
